[rtl/core/encoder_joint_stepper_stall_monitor_macros.svh]
// Assertion macros for the stepper stall monitor checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ENCODER_JOINT_STEPPER_STALL_MONITOR_MACROS_SVH
`define ENCODER_JOINT_STEPPER_STALL_MONITOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define EJSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EJSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ejss_pkg.sv]
// Shared types and constants for the stepper stall monitor.
// No dependencies.
`timescale 1ns / 1ps

package ejss_pkg;

    localparam int ANGLE_W  = 32;
    localparam int APC_W    = 32;
    localparam int PERIOD_W = 16;
    localparam int LIMIT_W  = 8;
    localparam int ENC_W    = 16;
    localparam int MISS_W   = 8;
    localparam int TICK_W   = 16;   // tick counter width, 4..32
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [APC_W-1:0]    APC_RESET    = APC_W'(6434);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(5);
    localparam logic [MISS_W-1:0]   MISS_MAX     = '1;

    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic signed [ENC_W-1:0]   enc_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_ANGLE   = 2'd0,
        REG_ANGLE_PER_COUNT = 2'd1,
        REG_STEP_PERIOD     = 2'd2,
        REG_MISSED_LIMIT    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic   operation;
        angle_t move_goal;
        enc_t   encoder_count;
    } cmd_t;

    typedef struct packed {
        logic   step_pulse;
        logic   direction_ccw;
        logic   move_done;
        logic   overtorqued;
        angle_t current_angle;
    } rsp_t;

    // Outcome of one motor step, from the angle unit
    typedef struct packed {
        angle_t angle;      // saturated new joint angle
        logic   stalled;    // no progress in commanded direction
        logic   reached;    // goal reached or passed
    } step_res_t;

endpackage

[rtl/core/ejss_if.sv]
// Handshake channels of the stepper stall monitor: command, result, config.
// Depends on ejss_pkg.
`timescale 1ns / 1ps

interface ejss_cmd_if;
    import ejss_pkg::*;
    logic   valid;
    logic   ready;
    logic   operation;
    angle_t move_goal;
    enc_t   encoder_count;
    modport source (output valid, output operation, output move_goal,
                    output encoder_count, input ready);
    modport sink   (input valid, input operation, input move_goal,
                    input encoder_count, output ready);
endinterface

interface ejss_rsp_if;
    import ejss_pkg::*;
    logic   valid;
    logic   ready;
    logic   step_pulse;
    logic   direction_ccw;
    logic   move_done;
    logic   overtorqued;
    angle_t current_angle;
    modport source (output valid, output step_pulse, output direction_ccw,
                    output move_done, output overtorqued, output current_angle,
                    input ready);
    modport sink   (input valid, input step_pulse, input direction_ccw,
                    input move_done, input overtorqued, input current_angle,
                    output ready);
endinterface

interface ejss_cfg_if;
    import ejss_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ejss_angle_step.sv]
// Angle update for one motor step: scaled encoder delta, saturation, progress.
// Depends on ejss_pkg.
`timescale 1ns / 1ps

module ejss_angle_step (
    input  ejss_pkg::enc_t              encoder_count,
    input  ejss_pkg::enc_t              last_count,
    input  logic [ejss_pkg::APC_W-1:0]  angle_per_count,
    input  ejss_pkg::angle_t            joint_angle,
    input  ejss_pkg::angle_t            goal_angle,
    input  logic                        ccw,
    output ejss_pkg::step_res_t         res
);
    import ejss_pkg::*;

    localparam int DELTA_W = ENC_W + 1;
    localparam int PROD_W  = DELTA_W + APC_W + 1;
    localparam int CHG_W   = PROD_W - 16;
    localparam int SUM_W   = CHG_W + 1;

    logic signed [DELTA_W-1:0] delta;
    logic signed [PROD_W-1:0]  prod;
    logic signed [CHG_W-1:0]   change;
    logic signed [SUM_W-1:0]   sum;
    angle_t                    angle;

    assign delta  = DELTA_W'(encoder_count) - DELTA_W'(last_count);
    assign prod   = PROD_W'(delta) * PROD_W'($signed({1'b0, angle_per_count}));
    // Q0.32 to Q16.16, floor for both signs
    assign change = prod[PROD_W-1:16];
    assign sum    = SUM_W'(joint_angle) + SUM_W'(change);

    always_comb
    begin
        if (sum[SUM_W-1:ANGLE_W-1] == '0 || sum[SUM_W-1:ANGLE_W-1] == '1)
        begin
            angle = sum[ANGLE_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            angle = {1'b1, {(ANGLE_W-1){1'b0}}};
        end
        else
        begin
            angle = {1'b0, {(ANGLE_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        res.angle = angle;
        if (ccw)
        begin
            res.stalled = (angle <= joint_angle);
            res.reached = (angle >= goal_angle);
        end
        else
        begin
            res.stalled = (angle >= joint_angle);
            res.reached = (angle <= goal_angle);
        end
    end

endmodule

[rtl/core/encoder_joint_stepper_stall_monitor.sv]
// Top level of the closed-loop stepper joint with encoder stall monitor.
// Depends on ejss_pkg, ejss_if.sv and ejss_angle_step.
//
// Usage
//   cmd : one word per item. operation = start move loads move_goal and
//         picks the direction; operation = tick advances the step period and,
//         on the first tick of a period while a move runs, issues a step and
//         samples encoder_count.
//   rsp : one word per command word: step flag, direction, done, overtorque
//         and the joint angle after that command.
//   cfg : register writes (initial angle, angle per count, step period,
//         missed-step limit), taken at once; cfg.ready is always high.
//         Writing the initial angle presets the joint angle. Write only idle.
// Timing
//   A command word passes through the input register, then one pass of step
//   logic (17x33 multiply, add, saturate, compares) into the result register,
//   which drives rsp. Throughput one word per cycle while rsp is not held;
//   the joint state loop closes in that single pass.
// Reset: all state cleared, move marked done, registers at their defaults,
//   no word held in either stage.
// Stall: while rsp is held, one more command word waits in the input
//   register; cmd.ready then drops until rsp.ready returns.
`timescale 1ns / 1ps

module encoder_joint_stepper_stall_monitor (
    input  logic          clk,
    input  logic          rst_n,
    ejss_cmd_if.sink      cmd,
    ejss_rsp_if.source    rsp,
    ejss_cfg_if.sink      cfg
);
    import ejss_pkg::*;

    // Configuration registers
    logic [APC_W-1:0]    apc_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    // Joint state
    angle_t              joint_reg,  joint_next;
    angle_t              goal_reg,   goal_next;
    logic                ccw_reg,    ccw_next;
    logic                done_reg,   done_next;
    enc_t                last_reg,   last_next;
    logic [MISS_W-1:0]   miss_reg,   miss_next;
    logic [TICK_W-1:0]   tick_reg,   tick_next;

    // Pipeline
    logic                s1_valid_reg;
    cmd_t                s1_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg,    rsp_next;

    logic                advance;
    logic                cmd_fire;
    logic                cfg_fire;
    logic [TICK_W-1:0]   tick_inc;
    step_res_t           step;

    assign advance  = !rsp_valid_reg || rsp.ready;   // result slot frees up
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_fire = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign cfg_fire = cfg.valid;

    ejss_angle_step u_angle_step (
        .encoder_count   (s1_reg.encoder_count),
        .last_count      (last_reg),
        .angle_per_count (apc_reg),
        .joint_angle     (joint_reg),
        .goal_angle      (goal_reg),
        .ccw             (ccw_reg),
        .res             (step)
    );

    assign tick_inc = tick_reg + 1'b1;

    // Next joint state for the word in the input register
    always_comb
    begin
        joint_next = joint_reg;
        goal_next  = goal_reg;
        ccw_next   = ccw_reg;
        done_next  = done_reg;
        last_next  = last_reg;
        miss_next  = miss_reg;
        tick_next  = tick_reg;
        rsp_next.step_pulse = 1'b0;

        if (s1_reg.operation == OP_START)
        begin
            goal_next = s1_reg.move_goal;
            tick_next = '0;
            if (s1_reg.move_goal > joint_reg)
            begin
                ccw_next  = 1'b1;
                done_next = 1'b0;
            end
            else if (s1_reg.move_goal < joint_reg)
            begin
                ccw_next  = 1'b0;
                done_next = 1'b0;
            end
            else
            begin
                done_next = 1'b1;   // already there, direction kept
            end
        end
        else if (done_reg || joint_reg == goal_reg)
        begin
            done_next = 1'b1;       // idle tick, counter frozen
        end
        else
        begin
            if (tick_reg == '0)
            begin
                rsp_next.step_pulse = 1'b1;
                last_next  = s1_reg.encoder_count;
                joint_next = step.angle;
                if (step.stalled)
                begin
                    if (miss_reg != MISS_MAX)
                    begin
                        miss_next = miss_reg + 1'b1;
                    end
                end
                else
                begin
                    miss_next = '0;
                end
                if (step.reached)
                begin
                    done_next = 1'b1;
                end
            end
            // zero period behaves as one
            if (32'(tick_inc) >= 32'(period_reg))
            begin
                tick_next = '0;
            end
            else
            begin
                tick_next = tick_inc;
            end
            if (miss_next > limit_reg)
            begin
                done_next = 1'b1;
            end
        end

        rsp_next.direction_ccw = ccw_next;
        rsp_next.move_done     = done_next;
        rsp_next.overtorqued   = (miss_next > limit_reg);
        rsp_next.current_angle = joint_next;
    end

    // Control and joint state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apc_reg       <= APC_RESET;
            period_reg    <= PERIOD_RESET;
            limit_reg     <= LIMIT_RESET;
            joint_reg     <= '0;
            goal_reg      <= '0;
            ccw_reg       <= 1'b0;
            done_reg      <= 1'b1;
            last_reg      <= '0;
            miss_reg      <= '0;
            tick_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && advance)
            begin
                joint_reg <= joint_next;
                goal_reg  <= goal_next;
                ccw_reg   <= ccw_next;
                done_reg  <= done_next;
                last_reg  <= last_next;
                miss_reg  <= miss_next;
                tick_reg  <= tick_next;
            end

            // The user must send config writes only while idle; the block does not enforce it
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_INITIAL_ANGLE:   joint_reg  <= cfg.data[ANGLE_W-1:0];
                    REG_ANGLE_PER_COUNT: apc_reg    <= cfg.data[APC_W-1:0];
                    REG_STEP_PERIOD:     period_reg <= cfg.data[PERIOD_W-1:0];
                    REG_MISSED_LIMIT:    limit_reg  <= cfg.data[LIMIT_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_reg.operation     <= cmd.operation;
            s1_reg.move_goal     <= cmd.move_goal;
            s1_reg.encoder_count <= cmd.encoder_count;
        end
        if (s1_valid_reg && advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.step_pulse    = rsp_reg.step_pulse;
    assign rsp.direction_ccw = rsp_reg.direction_ccw;
    assign rsp.move_done     = rsp_reg.move_done;
    assign rsp.overtorqued   = rsp_reg.overtorqued;
    assign rsp.current_angle = rsp_reg.current_angle;

endmodule

[rtl/core/ejss_checker.sv]
// Port-level checks for the stepper stall monitor, bound to the top level.
// Depends on ejss_pkg and encoder_joint_stepper_stall_monitor_macros.svh.
`timescale 1ns / 1ps
`include "encoder_joint_stepper_stall_monitor_macros.svh"

module ejss_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             step_pulse,
    input logic             direction_ccw,
    input logic             move_done,
    input logic             overtorqued,
    input ejss_pkg::angle_t current_angle
);
    import ejss_pkg::*;

    // Stalled result word holds still
    `EJSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable({step_pulse, direction_ccw, move_done, overtorqued,
        current_angle}), "result word changed while stalled")

    // Input only backs up when the result side is stalled
    `EJSS_ASSERT_NOW(a_cmd_backpressure, !cmd_ready,
        rsp_valid && !rsp_ready, "command stalled with result slot free")

    // An overtorque seen on a step always ends the move
    `EJSS_ASSERT_NOW(a_overtorque_done, rsp_valid && step_pulse && overtorqued,
        move_done, "step over the missed-step limit left move running")

    // Nothing to deliver straight out of reset
    `EJSS_ASSERT_NOW(a_reset_empty, !$past(rst_n),
        !rsp_valid, "result valid right after reset")

endmodule

bind encoder_joint_stepper_stall_monitor ejss_checker u_ejss_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_ready     (cmd.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .step_pulse    (rsp.step_pulse),
    .direction_ccw (rsp.direction_ccw),
    .move_done     (rsp.move_done),
    .overtorqued   (rsp.overtorqued),
    .current_angle (rsp.current_angle)
);

[dv/tb_top.sv]
// Self-checking bench for the closed-loop stepper joint and its stall monitor.
// Needs ejss_pkg, the channel interfaces in ejss_if.sv and the top-level RTL.
`timescale 1ns / 1ps

module tb_top;
    import ejss_pkg::*;

    localparam longint ANGLE_MAX      = 2147483647;
    localparam longint ANGLE_MIN      = -ANGLE_MAX - 1;
    localparam int     WATCHDOG_LIMIT = 1000;   // cycles with no handshake at all
    localparam int     DRAIN_CYCLES   = 4;      // two-stage pipe plus margin
    localparam int     PHASE_WORDS    = 60;
    localparam int     PHASES         = 8;

    // Tracks the joint as the block should see it and holds the status
    // words it owes us, oldest first.
    class joint_scoreboard;
        logic [APC_W-1:0]    angle_per_count;
        logic [PERIOD_W-1:0] step_period;
        logic [LIMIT_W-1:0]  miss_limit;

        angle_t              joint_angle;
        angle_t              goal_angle;
        logic                ccw;
        logic                done;
        enc_t                last_count;
        logic [MISS_W-1:0]   missed;
        logic [TICK_W-1:0]   tick_count;

        rsp_t                pending_status[$];
        int unsigned         errors;

        function new();
            angle_per_count = APC_RESET;
            step_period     = PERIOD_RESET;
            miss_limit      = LIMIT_RESET;
            joint_angle     = '0;
            goal_angle      = '0;
            ccw             = 1'b0;
            done            = 1'b1;
            last_count      = '0;
            missed          = '0;
            tick_count      = '0;
            errors          = 0;
        endfunction

        function void note_config(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_INITIAL_ANGLE:   joint_angle = angle_t'(value);  // presets the joint
                REG_ANGLE_PER_COUNT: angle_per_count = value[APC_W-1:0];
                REG_STEP_PERIOD:     step_period = value[PERIOD_W-1:0];
                REG_MISSED_LIMIT:    miss_limit = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the joint by one command word and return its status word
        function rsp_t step_joint(cmd_t word);
            rsp_t   status;
            longint delta;
            longint change;
            longint next_angle;
            logic   pulse;
            pulse = 1'b0;
            if (word.operation == OP_START) begin
                goal_angle = word.move_goal;
                tick_count = '0;
                if (goal_angle > joint_angle) begin
                    ccw  = 1'b1;
                    done = 1'b0;
                end
                else if (goal_angle < joint_angle) begin
                    ccw  = 1'b0;
                    done = 1'b0;
                end
                else
                    done = 1'b1;    // already there, direction left alone
            end
            else if (done || joint_angle == goal_angle)
                done = 1'b1;
            else begin
                if (tick_count == '0) begin
                    delta  = longint'($signed(word.encoder_count)) - longint'(last_count);
                    // Q0.32 product, arithmetic shift floors towards minus infinity
                    change = (delta * longint'({32'b0, angle_per_count})) >>> 16;
                    next_angle = longint'(joint_angle) + change;
                    if (next_angle > ANGLE_MAX)
                        next_angle = ANGLE_MAX;
                    else if (next_angle < ANGLE_MIN)
                        next_angle = ANGLE_MIN;
                    pulse      = 1'b1;
                    last_count = word.encoder_count;
                    if (ccw) begin
                        if (next_angle <= longint'(joint_angle)) begin
                            if (missed != MISS_MAX)
                                missed = missed + 1'b1;
                        end
                        else
                            missed = '0;
                        if (next_angle >= longint'(goal_angle))
                            done = 1'b1;
                    end
                    else begin
                        if (next_angle >= longint'(joint_angle)) begin
                            if (missed != MISS_MAX)
                                missed = missed + 1'b1;
                        end
                        else
                            missed = '0;
                        if (next_angle <= longint'(goal_angle))
                            done = 1'b1;
                    end
                    joint_angle = angle_t'(next_angle);
                end
                tick_count = tick_count + 1'b1;
                if (tick_count >= step_period)
                    tick_count = '0;
                if (missed > miss_limit)
                    done = 1'b1;
            end
            status.step_pulse    = pulse;
            status.direction_ccw = ccw;
            status.move_done     = done;
            status.overtorqued   = (missed > miss_limit);
            status.current_angle = joint_angle;
            return status;
        endfunction

        function void note_command(cmd_t word);
            pending_status.push_back(step_joint(word));
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_status.size() == 0) begin
                $error("status word with nothing outstanding: angle %0d",
                       got.current_angle);
                errors++;
                return;
            end
            want = pending_status.pop_front();
            compare_field("step_pulse", want.step_pulse, got.step_pulse);
            compare_field("direction_ccw", want.direction_ccw, got.direction_ccw);
            compare_field("move_done", want.move_done, got.move_done);
            compare_field("overtorqued", want.overtorqued, got.overtorqued);
            compare_field("current_angle", want.current_angle, got.current_angle);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ejss_cmd_if cmd_ch();
    ejss_rsp_if rsp_ch();
    ejss_cfg_if cfg_ch();

    encoder_joint_stepper_stall_monitor uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    joint_scoreboard sb = new();

    bit          cmd_burst;     // sender runs without gaps
    bit          rsp_burst;     // receiver never stalls
    int unsigned words_sent;
    int unsigned idle_cycles = 0;
    logic [APC_W-1:0] phase_apc;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender. Valid is only dropped when a gap is drawn, so back-to-back
    // words never see valid lowered and raised in the same step.
    task automatic send_cmd(input op_t op, input angle_t target, input enc_t count);
        cmd_t word;
        int   gap;
        gap = cmd_burst ? 0 : $urandom_range(0, 15);
        word.operation     = op;
        word.move_goal     = target;
        word.encoder_count = count;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= word.operation;
        cmd_ch.move_goal     <= word.move_goal;
        cmd_ch.encoder_count <= word.encoder_count;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.note_command(word);
        words_sent++;
    endtask

    // Register write; valid is lowered after each so it never toggles twice in a step
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.note_config(idx, value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and let every owed status word come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_status.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One start-move followed by ticks whose encoder mostly follows the
    // commanded direction, with stalls and the odd jump mixed in.
    task automatic run_move();
        longint per_count;
        longint offset;
        longint reach;
        angle_t target;
        enc_t   enc_pos;
        int     mode;
        int     ticks;
        int     pick;
        per_count = longint'(phase_apc >> 16) + 1;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            target = sb.joint_angle;                 // equal target
        else if (mode == 1)
            target = angle_t'($urandom());
        else
        begin
            offset = per_count * longint'($urandom_range(1, 40));
            if ($urandom_range(0, 1))
                offset = -offset;
            reach = longint'(sb.joint_angle) + offset;
            if (reach > ANGLE_MAX)
                reach = ANGLE_MAX;
            else if (reach < ANGLE_MIN)
                reach = ANGLE_MIN;
            target = angle_t'(reach);
        end
        send_cmd(OP_START, target, enc_t'($urandom()));
        enc_pos = sb.last_count;
        ticks = $urandom_range(2, 25);
        repeat (ticks)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                enc_pos = enc_t'(longint'(enc_pos) +
                          (sb.ccw ? 1 : -1) * longint'($urandom_range(1, 6)));
            else if (pick == 9)
                enc_pos = enc_t'($urandom());
            // otherwise the encoder stands still: a missed step
            send_cmd(OP_TICK, angle_t'($urandom()), enc_pos);
        end
    endtask

    // Receiver: random stall before each word, checked on acceptance
    initial
    begin
        int   stall;
        rsp_t got;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            stall = rsp_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_ch.valid && rst_n));
            got.step_pulse    = rsp_ch.step_pulse;
            got.direction_ccw = rsp_ch.direction_ccw;
            got.move_done     = rsp_ch.move_done;
            got.overtorqued   = rsp_ch.overtorqued;
            got.current_angle = rsp_ch.current_angle;
            sb.check_result(got);
        end
    end

    // Watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int               phase;
        int unsigned      phase_end;
        logic [PERIOD_W-1:0] period;
        logic [LIMIT_W-1:0]  limit;
        angle_t           start_angle;

        rst_n                <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.operation     <= OP_TICK;
        cmd_ch.move_goal     <= '0;
        cmd_ch.encoder_count <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_INITIAL_ANGLE;
        cfg_ch.data          <= '0;
        words_sent           = 0;
        cmd_burst            = 1'b0;
        rsp_burst            = 1'b0;
        phase_apc            = APC_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: reset defaults ---
        send_cmd(OP_TICK, 32'sh7FFF_FFFF, 16'sh7FFF);     // tick while done from reset
        send_cmd(OP_START, '0, '0);                       // target equals angle
        send_cmd(OP_START, 32'sh0001_0000, '0);           // counter-clockwise move
        send_cmd(OP_TICK, '0, 16'sh7FFF);                 // step, small gain
        send_cmd(OP_TICK, '0, '0);                        // inside the step period
        drain();

        // full gain, step every tick, no missed steps allowed
        write_reg(REG_INITIAL_ANGLE, 32'h7FFF_0000);
        write_reg(REG_ANGLE_PER_COUNT, '1);
        write_reg(REG_STEP_PERIOD, 32'd1);
        write_reg(REG_MISSED_LIMIT, 32'd0);
        send_cmd(OP_START, 32'sh7FFF_FFFF, '0);
        send_cmd(OP_TICK, '0, 16'sh8000);     // huge backward jump: lands exactly on the floor, stall
        send_cmd(OP_TICK, '0, 16'sh1234);     // tick after an overtorque abort
        send_cmd(OP_START, 32'sh8000_0000, '0);           // equal at minimum, ccw kept
        send_cmd(OP_START, '0, '0);           // new move, missed count not cleared
        send_cmd(OP_TICK, '0, 16'sh7FFF);     // huge forward jump: lands just under the ceiling
        send_cmd(OP_START, 32'sh8000_0000, '0);           // clockwise from the top
        send_cmd(OP_TICK, '0, '0);
        send_cmd(OP_TICK, '0, '0);            // no progress: stall abort
        drain();

        // longest period, highest missed-step limit that can still trip
        write_reg(REG_STEP_PERIOD, 32'd65535);
        write_reg(REG_MISSED_LIMIT, 32'd254);
        write_reg(REG_ANGLE_PER_COUNT, 32'h0100_0000);
        send_cmd(OP_START, 32'sh0000_03E8, '0);
        send_cmd(OP_TICK, '0, 16'sh8000);
        send_cmd(OP_TICK, '0, 16'sh0005);     // no step until the period expires
        send_cmd(OP_TICK, '0, 16'sh7FFF);

        // --- random phases, each with its own register setting ---
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            if (phase == 1)
                phase_apc = '0;
            else if (phase == 2)
                phase_apc = '1;
            else
                phase_apc = $urandom_range(32'h0004_0000, 32'h0400_0000);
            if (phase == 3)
                period = 16'hFFFF;
            else if (phase == 4)
                period = 16'd1;
            else
                period = PERIOD_W'($urandom_range(1, 6));
            if (phase == 5)
                limit = 8'd0;
            else if (phase == 6)
                limit = 8'd254;
            else
                limit = LIMIT_W'($urandom_range(0, 10));
            if (phase == 0)
                start_angle = 32'sh8000_0000;
            else if (phase == 7)
                start_angle = 32'sh7FFF_FFFF;
            else
                start_angle = angle_t'(longint'($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608);
            write_reg(REG_INITIAL_ANGLE, start_angle);
            write_reg(REG_ANGLE_PER_COUNT, phase_apc);
            write_reg(REG_STEP_PERIOD, {16'b0, period});
            write_reg(REG_MISSED_LIMIT, {24'b0, limit});

            // some phases run flat out on one or both sides
            cmd_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_cmd(op_t'($urandom_range(0, 1)), angle_t'($urandom()),
                             enc_t'($urandom()));
                else
                    run_move();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
